// ===== design/logistic_neuron_trainer_macros.svh =====
// Assertion macros shared by the checker of the logistic neuron trainer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LOGISTIC_NEURON_TRAINER_MACROS_SVH
`define LOGISTIC_NEURON_TRAINER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LNT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lnt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lnt assertion failed");

`endif

// ===== design/lnt_pkg.sv =====
// Package of the logistic neuron trainer: sizes, codes, control structs and
// the sigmoid lookup table built at elaboration. Depends on nothing.
`default_nettype none

package lnt_pkg;

  localparam int NUM_INPUTS   = 4;
  localparam int NUM_FEATURES = 4;
  localparam int NUM_LANES    = NUM_INPUTS + 1;
  localparam int TABLE_DEPTH  = 256;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);

  localparam int X_W    = 16;
  localparam int W_W    = 24;
  localparam int PROD_W = X_W + W_W;
  localparam int GS_W   = 40;
  localparam int ERR_W  = 14;
  localparam int ACT_W  = 13;
  localparam int LR_W   = 16;
  localparam int PI_W   = 3;

  localparam logic [ACT_W-1:0] ONE_Q12    = 13'd4096;
  localparam logic [X_W-1:0]   BIAS_INPUT = 16'd4096;
  localparam logic [LR_W-1:0]  LR_RESET   = 16'd4096;
  localparam logic [PI_W-1:0]  PARAM_BIAS = 3'd4;

  typedef enum logic [1:0] {
    ACT_TRAIN  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_LOAD   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_PROD,
    LANE_GRAD,
    LANE_UMUL,
    LANE_UAPPLY,
    LANE_LOAD
  } lane_op_e;

  typedef struct packed {
    lane_op_e                 op;
    logic signed [ERR_W-1:0]  err;
    logic [LR_W-1:0]          lr;
    logic signed [W_W-1:0]    value;
  } lane_ctrl_t;

  typedef struct packed {
    logic sum_en;
    logic act_en;
  } merge_ctrl_t;

  typedef logic [NUM_LANES-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [TABLE_DEPTH-1:0][ACT_W-1:0] sig_table_t;

  // Restoring division, used only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_table_t build_sig_table();
    logic [63:0] bitexp [16];
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [15:0] n;
    int          c;
    sig_table_t  t;
    bitexp[0] = (64'd1 << 31) - (64'd1 << 19) + 64'd64;
    for (int b = 1; b < 16; b++) begin
      bitexp[b] = (bitexp[b-1] * bitexp[b-1] + (64'd1 << 30)) >> 31;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      c = -32768 + (((2 * k + 1) * 32768) >> IDX_W);
      n = 16'((c < 0) ? -c : c);
      e = 64'd1 << 31;
      for (int b = 0; b < 16; b++) begin
        if (n[b]) begin
          e = (e * bitexp[b] + (64'd1 << 30)) >> 31;
        end
      end
      den = (64'd1 << 31) + e;
      num = (c >= 0) ? (64'd4096 << 31) : (64'd4096 * e);
      t[k] = ACT_W'(udiv64(num + (den >> 1), den));
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ===== design/lnt_lane.sv =====
// One lane of the neuron: holds a weight and its gradient sum, forms x*w,
// accumulates e*x and applies the learning-rate step. Depends on lnt_pkg.
`default_nettype none

module lnt_lane
  import lnt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lane_ctrl_t             ctrl_i,
  input  wire logic                   load_en_i,
  input  wire logic signed [X_W-1:0]  x_i,
  output logic        [PROD_W-1:0]    prod_o
);

  localparam int STEP_W = GS_W + LR_W + 1;
  localparam int RND_W  = STEP_W + 1;
  localparam int D_W    = RND_W - 20;
  localparam int DIFF_W = D_W + 1;

  logic signed [W_W-1:0]    w_q, w_d;
  logic signed [GS_W-1:0]   gsum_q, gsum_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [STEP_W-1:0] step_q;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W+X_W-1:0] ex;
  logic signed [GS_W:0]     gsum_sum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [D_W-1:0]    delta;
  logic signed [DIFF_W-1:0] diff;

  assign err      = ctrl_i.err;
  assign ex       = err * x_i;
  assign gsum_sum = (GS_W+1)'(gsum_q) + (GS_W+1)'(ex);
  assign rnd      = RND_W'(step_q) + (RND_W'(1) <<< 19);
  assign delta    = rnd[RND_W-1:20];
  assign diff     = DIFF_W'(w_q) - DIFF_W'(delta);

  always_comb begin
    w_d    = w_q;
    gsum_d = gsum_q;
    case (ctrl_i.op)
      LANE_GRAD: begin
        if (gsum_sum[GS_W] != gsum_sum[GS_W-1]) begin
          gsum_d = gsum_sum[GS_W] ? {1'b1, {(GS_W-1){1'b0}}} : {1'b0, {(GS_W-1){1'b1}}};
        end else begin
          gsum_d = gsum_sum[GS_W-1:0];
        end
      end
      LANE_UAPPLY: begin
        gsum_d = '0;
        if (diff[DIFF_W-1:W_W-1] != {(DIFF_W-W_W+1){diff[W_W-1]}}) begin
          w_d = diff[DIFF_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end else begin
          w_d = diff[W_W-1:0];
        end
      end
      LANE_LOAD: begin
        if (load_en_i) begin
          w_d = ctrl_i.value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      gsum_q <= '0;
    end else begin
      w_q    <= w_d;
      gsum_q <= gsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == LANE_PROD) begin
      prod_q <= x_i * w_q;
    end
    if (ctrl_i.op == LANE_UMUL) begin
      step_q <= gsum_q * $signed({1'b0, ctrl_i.lr});
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== design/lnt_merge.sv =====
// Merging stage: sums the lane products into z, rounds and saturates it,
// looks up the sigmoid and forms the error. Depends on lnt_pkg.
`default_nettype none

module lnt_merge
  import lnt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire merge_ctrl_t            ctrl_i,
  input  wire prod_vec_t              prod_i,
  input  wire logic [ACT_W-1:0]       label_i,
  output logic signed [X_W-1:0]       z_o,
  output logic        [ACT_W-1:0]     act_o,
  output logic signed [ERR_W-1:0]     err_o
);

  localparam int ACC_W = PROD_W + $clog2(NUM_LANES) + 1;
  localparam int SH_W  = ACC_W - 16;

  logic signed [ACC_W-1:0] acc;
  logic signed [SH_W-1:0]  shifted;
  logic signed [X_W-1:0]   z_d;
  logic [X_W-1:0]          zoff;
  logic [ACT_W-1:0]        act_d;
  logic [ACT_W-1:0]        lbl;
  logic signed [ERR_W-1:0] err_d;

  logic signed [X_W-1:0]   z_q;
  logic [ACT_W-1:0]        act_q;
  logic signed [ERR_W-1:0] err_q;

  always_comb begin
    acc = ACC_W'(32768);
    for (int i = 0; i < NUM_LANES; i++) begin
      acc = acc + ACC_W'($signed(prod_i[i]));
    end
    shifted = acc[ACC_W-1:16];
    if (shifted[SH_W-1:X_W-1] != {(SH_W-X_W+1){shifted[X_W-1]}}) begin
      z_d = shifted[SH_W-1] ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}};
    end else begin
      z_d = shifted[X_W-1:0];
    end
  end

  assign zoff  = {~z_q[X_W-1], z_q[X_W-2:0]};
  assign act_d = SIG_TABLE[zoff[X_W-1 -: IDX_W]];
  assign lbl   = (label_i > ONE_Q12) ? ONE_Q12 : label_i;
  assign err_d = $signed({1'b0, act_d}) - $signed({1'b0, lbl});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      z_q <= z_d;
    end
    if (ctrl_i.act_en) begin
      act_q <= act_d;
      err_q <= err_d;
    end
  end

  assign z_o   = z_q;
  assign act_o = act_q;
  assign err_o = err_q;

endmodule

`default_nettype wire

// ===== design/logistic_neuron_trainer.sv =====
// Top level of the logistic neuron trainer: request sequencer, one lane per
// weight plus a bias lane, the merging stage and the result register.
// Depends on lnt_pkg, lnt_lane and lnt_merge.
//
// Requests enter on the s_axis channel: tuser carries the action, tdata the
// features, label and load fields. One result leaves on m_axis per request.
// The learning rate is written through cfg_we_i/cfg_wdata_i while idle; the
// user is bound to this, as the block itself does not enforce it. A train
// request passes through one multiply in every lane, a merge add with
// rounding and saturation, the sigmoid table read, the gradient
// multiply-accumulate and the output write. An update passes through a lane
// multiply by the rate, subtract and saturate, and the output write; a load
// or an unused action goes to the output write. After each result the
// sequencer returns to idle. One request is in work at a time; the next is
// taken at idle even while the previous result still waits in the output
// register. If the receiver stalls, the result holds and a finished request
// waits until the output register frees. Reset clears weights, bias,
// gradient sums and the output valid and sets the learning rate to 1.0.
`default_nettype none

module logistic_neuron_trainer
  import lnt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  // feature_0[15:0], feature_1[31:16], feature_2[47:32], feature_3[63:48],
  // label[76:64], param_index[79:77], param_value[103:80]
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // weighted_sum[15:0], activation[28:16], error[42:29], zero[47:43]
  output logic [47:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_SUM,
    S_ACT,
    S_GRAD,
    S_UMUL,
    S_UAPPLY,
    S_LOAD_OUT
  } state_e;

  state_e                 state_q;
  logic                   busy_out_q;
  logic                   m_valid_q;
  logic signed [X_W-1:0]  out_z_q;
  logic [ACT_W-1:0]       out_act_q;
  logic signed [ERR_W-1:0] out_err_q;
  logic [LR_W-1:0]        lr_q;

  logic [1:0]             action_q;
  logic signed [X_W-1:0]  x_q [NUM_FEATURES];
  logic [ACT_W-1:0]       label_q;
  logic [PI_W-1:0]        pi_q;
  logic signed [W_W-1:0]  value_q;

  logic                   s_accept;
  logic                   out_free;
  logic                   out_load;
  lane_ctrl_t             lane_ctrl;
  merge_ctrl_t            merge_ctrl;
  prod_vec_t              prods;
  logic signed [X_W-1:0]  z;
  logic [ACT_W-1:0]       act;
  logic signed [ERR_W-1:0] err;
  logic                   is_train;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_LOAD_OUT) && busy_out_q && out_free;
  assign is_train = (action_q == ACT_TRAIN);

  always_comb begin
    lane_ctrl.err   = err;
    lane_ctrl.lr    = lr_q;
    lane_ctrl.value = value_q;
    unique case (state_q)
      S_PROD:   lane_ctrl.op = LANE_PROD;
      S_GRAD:   lane_ctrl.op = LANE_GRAD;
      S_UMUL:   lane_ctrl.op = LANE_UMUL;
      S_UAPPLY: lane_ctrl.op = LANE_UAPPLY;
      S_LOAD_OUT: begin
        lane_ctrl.op = (action_q == ACT_LOAD && !busy_out_q) ? LANE_LOAD : LANE_IDLE;
      end
      default:  lane_ctrl.op = LANE_IDLE;
    endcase
    merge_ctrl.sum_en = (state_q == S_SUM);
    merge_ctrl.act_en = (state_q == S_ACT);
  end

  for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
    logic signed [X_W-1:0] lane_x;
    logic                  lane_load;
    if (i < NUM_FEATURES) begin : g_feat
      assign lane_x = x_q[i];
    end else begin : g_nofeat
      assign lane_x = '0;
    end
    assign lane_load = (pi_q == PI_W'(i)) && (pi_q < PI_W'(NUM_FEATURES));
    lnt_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .load_en_i (lane_load),
      .x_i       (lane_x),
      .prod_o    (prods[i])
    );
  end

  lnt_lane u_bias_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lane_ctrl),
    .load_en_i (pi_q == PARAM_BIAS),
    .x_i       ($signed(BIAS_INPUT)),
    .prod_o    (prods[NUM_INPUTS])
  );

  lnt_merge u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (merge_ctrl),
    .prod_i  (prods),
    .label_i (label_q),
    .z_o     (z),
    .act_o   (act),
    .err_o   (err)
  );

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      action_q <= s_axis_tuser;
      for (int i = 0; i < NUM_FEATURES; i++) begin
        x_q[i] <= s_axis_tdata[i*X_W +: X_W];
      end
      label_q <= s_axis_tdata[76:64];
      pi_q    <= s_axis_tdata[79:77];
      value_q <= s_axis_tdata[103:80];
    end
  end

  // S_LOAD_OUT first applies a load (busy_out_q low), then waits for the
  // output register and writes the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_out_q <= 1'b0;
      m_valid_q  <= 1'b0;
      out_z_q    <= '0;
      out_act_q  <= '0;
      out_err_q  <= '0;
      lr_q       <= LR_RESET;
    end else begin
      if (cfg_we_i) begin
        lr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          busy_out_q <= 1'b0;
          if (s_accept) begin
            unique case (s_axis_tuser)
              ACT_TRAIN:  state_q <= S_PROD;
              ACT_UPDATE: state_q <= S_UMUL;
              default:    state_q <= S_LOAD_OUT;
            endcase
          end
        end
        S_PROD:   state_q <= S_SUM;
        S_SUM:    state_q <= S_ACT;
        S_ACT:    state_q <= S_GRAD;
        S_GRAD:   begin
          state_q    <= S_LOAD_OUT;
          busy_out_q <= 1'b1;
        end
        S_UMUL:   state_q <= S_UAPPLY;
        S_UAPPLY: begin
          state_q    <= S_LOAD_OUT;
          busy_out_q <= 1'b1;
        end
        S_LOAD_OUT: begin
          busy_out_q <= 1'b1;
          if (out_load) begin
            out_z_q   <= is_train ? z : '0;
            out_act_q <= is_train ? act : '0;
            out_err_q <= is_train ? err : '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_err_q, out_act_q, out_z_q};

endmodule

`default_nettype wire

// ===== design/lnt_checker.sv =====
// Port-level checker of the logistic neuron trainer and its bind statement.
// Depends on logistic_neuron_trainer_macros.svh and the top level's ports.
`default_nettype none
`include "logistic_neuron_trainer_macros.svh"

module lnt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  `LNT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `LNT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LNT_ASSERT_NOW(a_act_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[28:16] <= 13'd4096)
  `LNT_ASSERT_NOW(a_err_range, clk_i, rst_ni, m_axis_tvalid, ($signed(m_axis_tdata[42:29]) <= 14'sd4096) && ($signed(m_axis_tdata[42:29]) >= -14'sd4096) && (m_axis_tdata[47:43] == 5'd0))

endmodule

bind logistic_neuron_trainer lnt_checker u_lnt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for logistic_neuron_trainer: it drives train, update and load requests
// and checks every result against a bit-exact neuron model that the bench keeps alongside.
// Depends on lnt_pkg and the logistic_neuron_trainer RTL.
`default_nettype none

module testbench
  import lnt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_REPORTS    = 10;
  localparam int         DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [1:0]                        action;
    logic signed [W_W-1:0]             param_value;
    logic [PI_W-1:0]                   param_index;
    logic [ACT_W-1:0]                  label;
    logic [NUM_FEATURES-1:0][X_W-1:0]  feature;
  } request_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] error;
    logic [ACT_W-1:0]        activation;
    logic signed [X_W-1:0]   weighted_sum;
  } response_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;

  logic [ACT_W-1:0] sigmoid_lut [TABLE_DEPTH];
  longint           weight_param [NUM_INPUTS];
  longint           weight_grad [NUM_INPUTS];
  longint           bias_param;
  longint           bias_grad;
  logic [LR_W-1:0]  learning_rate_cfg = LR_RESET;

  response_t expected_responses [$];
  bit        steady_traffic = 1'b0;
  bit        run_complete = 1'b0;
  int        mismatch_count = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  int        n_train = 0;
  int        n_update = 0;
  int        n_load = 0;
  int        n_unused = 0;
  int        n_rate_writes = 0;

  logistic_neuron_trainer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void build_sigmoid_lut();
    longint unsigned step [16];
    longint unsigned e;
    longint unsigned den;
    longint unsigned num;
    int              c;
    int unsigned     n;
    step[0] = (64'd1 << 31) - (64'd1 << 19) + 64'd64;
    for (int b = 1; b < 16; b++) begin
      step[b] = (step[b-1] * step[b-1] + (64'd1 << 30)) >> 31;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      c = -32768 + ((2 * k + 1) * 32768) / TABLE_DEPTH;
      n = (c < 0) ? -c : c;
      e = 64'd1 << 31;
      for (int b = 0; b < 16; b++) begin
        if (n[b]) begin
          e = (e * step[b] + (64'd1 << 30)) >> 31;
        end
      end
      den = (64'd1 << 31) + e;
      num = (c >= 0) ? (64'd4096 << 31) : (64'd4096 * e);
      sigmoid_lut[k] = ACT_W'((num + den / 2) / den);
    end
  endfunction

  function automatic response_t compute_neuron_response(request_t r);
    response_t resp;
    longint    x [NUM_INPUTS];
    longint    acc;
    longint    z;
    longint    err;
    longint    lbl;
    longint    delta;
    int        idx;
    resp = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      x[i] = (i < NUM_FEATURES) ? longint'($signed(r.feature[i])) : 0;
    end
    case (r.action)
      ACT_TRAIN: begin
        acc = bias_param * longint'(BIAS_INPUT);
        for (int i = 0; i < NUM_INPUTS; i++) begin
          acc += x[i] * weight_param[i];
        end
        z = clamp_signed((acc + 32768) >>> 16, X_W);
        idx = int'(((z + 32768) * TABLE_DEPTH) >>> 16);
        if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
        lbl = (r.label > ONE_Q12) ? longint'(ONE_Q12) : longint'(r.label);
        err = longint'(sigmoid_lut[idx]) - lbl;
        for (int i = 0; i < NUM_INPUTS; i++) begin
          weight_grad[i] = clamp_signed(weight_grad[i] + err * x[i], GS_W);
        end
        bias_grad = clamp_signed(bias_grad + err * longint'(BIAS_INPUT), GS_W);
        resp.weighted_sum = X_W'(z);
        resp.activation   = sigmoid_lut[idx];
        resp.error        = ERR_W'(err);
      end
      ACT_UPDATE: begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
          delta = (weight_grad[i] * longint'(learning_rate_cfg) + 524288) >>> 20;
          weight_param[i] = clamp_signed(weight_param[i] - delta, W_W);
          weight_grad[i] = 0;
        end
        delta = (bias_grad * longint'(learning_rate_cfg) + 524288) >>> 20;
        bias_param = clamp_signed(bias_param - delta, W_W);
        bias_grad = 0;
      end
      ACT_LOAD: begin
        if (r.param_index == PARAM_BIAS) begin
          bias_param = longint'($signed(r.param_value));
        end else if (r.param_index < NUM_INPUTS) begin
          weight_param[r.param_index] = longint'($signed(r.param_value));
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  function automatic request_t random_request(logic [1:0] action);
    request_t r;
    r.action      = action;
    r.feature     = {$urandom, $urandom};
    r.label       = ACT_W'($urandom);
    r.param_index = PI_W'($urandom);
    r.param_value = W_W'($urandom);
    return r;
  endfunction

  function automatic request_t make_train(logic [15:0] f0, logic [15:0] f1, logic [15:0] f2,
                                          logic [15:0] f3, logic [ACT_W-1:0] lbl);
    request_t r;
    r = random_request(ACT_TRAIN);
    r.feature = {f3, f2, f1, f0};
    r.label   = lbl;
    return r;
  endfunction

  function automatic request_t make_load(logic [PI_W-1:0] idx, logic [W_W-1:0] value);
    request_t r;
    r = random_request(ACT_LOAD);
    r.param_index = idx;
    r.param_value = value;
    return r;
  endfunction

  task automatic send_request(request_t r);
    int        gap;
    response_t resp;
    if (!steady_traffic && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {r.param_value, r.param_index, r.label, r.feature};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    resp = compute_neuron_response(r);
    expected_responses = {expected_responses, resp};
    case (r.action)
      ACT_TRAIN:  n_train++;
      ACT_UPDATE: n_update++;
      ACT_LOAD:   n_load++;
      default:    n_unused++;
    endcase
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_learning_rate(logic [LR_W-1:0] rate);
    wait_until_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    learning_rate_cfg = rate;
    n_rate_writes++;
  endtask

  task automatic test_after_reset();
    send_request(make_train(16'h0000, 16'h0000, 16'h0000, 16'h0000, ONE_Q12));
    send_request(random_request(ACT_UPDATE));
    send_request(make_train(16'h1000, 16'hF000, 16'h0800, 16'h0000, 13'd0));
  endtask

  task automatic test_parameter_loads();
    for (int i = 0; i < 8; i++) begin
      send_request(make_load(PI_W'(i), (i % 2 == 1) ? 24'h800000 : 24'h7FFFFF));
    end
    send_request(make_train(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'h1FFF));
    send_request(make_train(16'h8000, 16'h8000, 16'h8000, 16'h8000, 13'd0));
    send_request(make_train(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, ONE_Q12));
    send_request(random_request(ACT_UNUSED));
    send_request(random_request(ACT_UPDATE));
  endtask

  task automatic test_rate_extremes();
    write_learning_rate(16'h0000);
    send_request(make_train(16'h2000, 16'hE000, 16'h0400, 16'hFC00, ONE_Q12));
    send_request(random_request(ACT_UPDATE));
    write_learning_rate(16'hFFFF);
    send_request(make_train(16'h0100, 16'hFF00, 16'h0010, 16'hFFF0, 13'd0));
    send_request(random_request(ACT_UPDATE));
    write_learning_rate(LR_RESET);
  endtask

  task automatic test_random_training();
    request_t r;
    int       sent;
    int       batch;
    int       roll;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase != 0) begin
        case ($urandom_range(0, 5))
          0:       write_learning_rate(16'h0000);
          1:       write_learning_rate(16'hFFFF);
          2:       write_learning_rate(LR_RESET);
          default: write_learning_rate(LR_W'($urandom_range(1, 1024)));
        endcase
      end
      steady_traffic = (phase == 5);
      if ($urandom_range(0, 9) < 3) begin
        for (int i = 0; i <= NUM_INPUTS; i++) begin
          send_request(make_load(PI_W'(i), W_W'(int'($urandom_range(0, 131071)) - 65536)));
        end
      end
      sent = 0;
      while (sent < 110) begin
        batch = $urandom_range(1, 16);
        for (int j = 0; j < batch; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 3) begin
            r = random_request(2'($urandom));
          end else if (roll < 5) begin
            r = random_request(ACT_LOAD);
          end else begin
            r = random_request(ACT_TRAIN);
            if ($urandom_range(0, 3) != 0) begin
              for (int i = 0; i < NUM_FEATURES; i++) begin
                r.feature[i] = X_W'(int'($urandom_range(0, 16383)) - 8192);
              end
            end
            if ($urandom_range(0, 3) != 0) begin
              r.label = (int'($signed(r.feature[0])) + int'($signed(r.feature[1]))
                         > int'($signed(r.feature[2]))) ? ONE_Q12 : 13'd0;
            end
          end
          send_request(r);
          sent++;
        end
        send_request(random_request(ACT_UPDATE));
        sent++;
        if ($urandom_range(0, 9) == 0) begin
          wait_until_drained();
        end
      end
    end
    steady_traffic = 1'b0;
  endtask

  task automatic test_weight_saturation();
    write_learning_rate(16'hFFFF);
    for (int i = 0; i < NUM_INPUTS; i++) begin
      send_request(make_load(PI_W'(i), 24'h000000));
    end
    send_request(make_load(PARAM_BIAS, 24'h7FFFFF));
    // With the bias at full scale the activation pins near one, so every sample
    // pushes the sums the same way and the next update drives the parameters
    // into saturation.
    for (int j = 0; j < 200; j++) begin
      send_request(make_train(X_W'(-int'($urandom_range(30000, 32768))),
                              X_W'(-int'($urandom_range(30000, 32768))),
                              X_W'($urandom_range(30000, 32767)),
                              X_W'($urandom_range(30000, 32767)),
                              ACT_W'($urandom_range(0, 64))));
    end
    send_request(random_request(ACT_UPDATE));
    send_request(make_train(16'h1000, 16'h1000, 16'h1000, 16'h1000, ONE_Q12));
    send_request(make_train(16'hF000, 16'h0800, 16'hF800, 16'h1000, 13'd0));
    send_request(random_request(ACT_UPDATE));
    write_learning_rate(LR_RESET);
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
               field, results_seen, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= steady_traffic || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_responses.size() == 0) begin
        note_mismatch("result with no request pending", 32'd0, m_axis_tdata[31:0]);
      end else begin
        want = expected_responses.pop_front();
        if (m_axis_tdata[15:0] !== want.weighted_sum) begin
          note_mismatch("weighted_sum", want.weighted_sum, m_axis_tdata[15:0]);
        end
        if (m_axis_tdata[28:16] !== want.activation) begin
          note_mismatch("activation", want.activation, m_axis_tdata[28:16]);
        end
        if (m_axis_tdata[42:29] !== want.error) begin
          note_mismatch("error", want.error, m_axis_tdata[42:29]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !run_complete) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding",
                 expected_responses.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    build_sigmoid_lut();
    for (int i = 0; i < NUM_INPUTS; i++) begin
      weight_param[i] = 0;
      weight_grad[i]  = 0;
    end
    bias_param = 0;
    bias_grad  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_parameter_loads();
    test_rate_extremes();
    test_random_training();
    test_weight_saturation();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    run_complete = 1'b1;
    mismatch_count += expected_responses.size();

    $display("Covered %0d train, %0d update, %0d load and %0d unused-action requests.",
             n_train, n_update, n_load, n_unused);
    $display("Learning rate set %0d times incl. zero and full scale; %0d results checked.",
             n_rate_writes, results_seen);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
